// File: hw/rtl/mrt_pkg.sv
// Shared types, constants and helpers for the MMIO range table.
`default_nettype none

package mrt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PAGE_BITS   = 12;

  localparam logic [15:0] ALIGN_MASK_RESET = 16'd4095;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } mrt_state_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [1:0]  flags;
  } mrt_entry_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] end_addr;
  } mrt_probe_t;

  typedef struct packed {
    logic active;
    logic load;
    logic shift;
  } mrt_cell_ctrl_t;

  // Lowest set bit position, zero when none set.
  function automatic logic [IDX_W-1:0] first_hit(input logic [TABLE_DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrt_if.sv
// Valid/ready channel interfaces for request, response and configuration.
`default_nettype none

interface mrt_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] base_addr;
  logic [63:0] range_length;
  logic [1:0]  dyntrans_flags;
  logic [4:0]  remove_index;

  modport source (output valid, req_type, base_addr, range_length, dyntrans_flags,
                  remove_index, input ready);
  modport sink (input valid, req_type, base_addr, range_length, dyntrans_flags,
                remove_index, output ready);
endinterface

interface mrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        collided;
  logic [4:0]  collision_index;
  logic        unaligned;
  logic [5:0]  entry_count;
  logic [63:0] window_low;
  logic [63:0] window_high;

  modport source (output valid, status, collided, collision_index, unaligned,
                  entry_count, window_low, window_high, input ready);
  modport sink (input valid, status, collided, collision_index, unaligned,
                entry_count, window_low, window_high, output ready);
endinterface

interface mrt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mrt_cell.sv
// One table slot: holds a range, checks it against the probe, shifts down on remove.
`default_nettype none

module mrt_cell
  import mrt_pkg::*;
(
  input  logic           clk,
  input  mrt_cell_ctrl_t ctrl,
  input  mrt_probe_t     probe,
  input  mrt_entry_t     new_entry,
  input  mrt_entry_t     neighbor,
  output mrt_entry_t     entry,
  output logic           hit
);

  logic [63:0] limit;

  assign limit = entry.base + entry.length;
  assign hit   = ctrl.active && !(probe.end_addr <= entry.base) && !(probe.base >= limit);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= new_entry;
    end else if (ctrl.shift) begin
      entry <= neighbor;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mmio_range_table.sv
// Top level of the MMIO range table: control, window tracking and the row of slots.
// A request passes through latch, evaluate and respond in turn after it is accepted.
// The next request is taken in the same cycle the previous response loads, so requests do
//   not overlap, and a full response register holds back both the response and the next request.
// Reset: rst (synchronous, active high) empties the table, sets the window to all ones /
//   zero and the alignment mask to 4095. Slot contents are not cleared; only slots below
//   the entry count are ever looked at.
`default_nettype none

module mmio_range_table
  import mrt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  mrt_cfg_if.sink   cfg,
  mrt_req_if.sink   req,
  mrt_rsp_if.source rsp
);

  // Control state
  mrt_state_t state, state_next;
  logic       in_ready;
  logic       out_load;
  logic       out_free;

  // Latched request
  logic        req_kind;
  logic [63:0] req_base;
  logic [63:0] req_length;
  logic [63:0] req_end;
  logic [1:0]  req_flags;
  logic [4:0]  req_index;

  // Table state
  logic [15:0]      align_mask;
  logic [CNT_W-1:0] count;
  logic [63:0]      min_window;
  logic [63:0]      max_window;

  // Evaluate-cycle results
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [1:0]             eval_status;
  logic                   eval_unaligned;

  // Response register
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_collided;
  logic [4:0]  out_cidx;
  logic        out_unaligned;
  logic [5:0]  out_count;
  logic [63:0] out_low;
  logic [63:0] out_high;

  // Evaluate-cycle decisions
  logic        eval_go;
  logic        is_add;
  logic        full;
  logic        add_ok;
  logic        rm_ok;
  logic [1:0]  status_c;
  logic        unaligned_c;
  logic [63:0] end_up;

  // Slot row wiring
  mrt_probe_t             probe;
  mrt_entry_t             new_entry;
  mrt_entry_t             cell_q   [TABLE_DEPTH];
  mrt_entry_t             cell_nb  [TABLE_DEPTH];
  mrt_cell_ctrl_t         cell_ctrl[TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_c;

  // Configuration: always ready, idle-only writes by contract.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      align_mask <= ALIGN_MASK_RESET;
    end else if (cfg.valid) begin
      align_mask <= cfg.data;
    end
  end

  // Handshake control: take a new request when idle, or when the finished
  // response can move into the output register in this very cycle.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (req.valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          in_ready   = 1'b1;
          state_next = req.valid ? ST_EVAL : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Latch the request; precompute the wrapped end address.
  always_ff @(posedge clk) begin
    if (req.valid && in_ready) begin
      req_kind   <= req.req_type;
      req_base   <= req.base_addr;
      req_length <= req.range_length;
      req_end    <= req.base_addr + req.range_length;
      req_flags  <= req.dyntrans_flags;
      req_index  <= req.remove_index;
    end
  end

  // Decide what the request does against the current count.
  assign eval_go = (state == ST_EVAL);
  assign is_add  = (req_kind == REQ_ADD);
  assign full    = (count == CNT_W'(TABLE_DEPTH));
  assign add_ok  = is_add && !full;
  assign rm_ok   = !is_add && (32'(req_index) < 32'(count));

  always_comb begin
    if (is_add) begin
      status_c = full ? STATUS_FULL : STATUS_DONE;
    end else begin
      status_c = rm_ok ? STATUS_DONE : STATUS_BAD_INDEX;
    end
  end

  assign unaligned_c = add_ok && (req_flags != 2'd0) && ((req_base[15:0] & align_mask) != 16'd0);

  // Round the end address up to the next page: ((end - 1) | 0xfff) + 1,
  // which keeps the end when it is already page aligned (including zero).
  assign end_up = (req_end[PAGE_BITS-1:0] == '0) ? req_end
                : {req_end[63:PAGE_BITS] + (64 - PAGE_BITS)'(1), PAGE_BITS'(0)};

  // Slot row: every slot compares against the probe at once; a remove moves
  // each slot above the index one place down, an add fills slot count.
  assign probe     = '{base: req_base, end_addr: req_end};
  assign new_entry = '{base: req_base, length: req_length, flags: req_flags};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i] = '{
      active: (CNT_W'(i) < count),
      load:   eval_go && add_ok && (CNT_W'(i) == count),
      shift:  eval_go && rm_ok && (32'(i) >= 32'(req_index))
              && (32'(i) + 32'd1 < 32'(count))
    };

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign cell_nb[i] = cell_q[i];
    end else begin : g_mid
      assign cell_nb[i] = cell_q[i + 1];
    end

    mrt_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .probe     (probe),
      .new_entry (new_entry),
      .neighbor  (cell_nb[i]),
      .entry     (cell_q[i]),
      .hit       (hit_c[i])
    );
  end

  // Evaluate cycle: capture hits and flags, update count and window.
  always_ff @(posedge clk) begin
    if (eval_go) begin
      hit_vec        <= add_ok ? hit_c : '0;
      eval_status    <= status_c;
      eval_unaligned <= unaligned_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      min_window <= '1;
      max_window <= '0;
    end else if (eval_go) begin
      if (add_ok) begin
        count <= count + CNT_W'(1);
        if (req_base < min_window) begin
          min_window <= {req_base[63:PAGE_BITS], PAGE_BITS'(0)};
        end
        if (req_end > max_window) begin
          max_window <= end_up;
        end
      end else if (rm_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Response register: hold until taken, load the lowest colliding index.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status    <= eval_status;
      out_collided  <= |hit_vec;
      out_cidx      <= 5'(first_hit(hit_vec));
      out_unaligned <= eval_unaligned;
      out_count     <= 6'(count);
      out_low       <= min_window;
      out_high      <= max_window;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.collided        = out_collided;
  assign rsp.collision_index = out_cidx;
  assign rsp.unaligned       = out_unaligned;
  assign rsp.entry_count     = out_count;
  assign rsp.window_low      = out_low;
  assign rsp.window_high     = out_high;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= TABLE_DEPTH)
    else $error("entry count exceeds table depth");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_EVAL))
    else $error("accepted request did not enter evaluation");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !eval_go |=> (count == $past(count)))
    else $error("entry count changed outside evaluation");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("response raised outside the done state");

  a_collide_only_add: assert property (@(posedge clk) disable iff (rst)
    (eval_go && !add_ok) |=> (hit_vec == '0 && !eval_unaligned))
    else $error("collision or alignment flag on a request that adds nothing");
`endif

endmodule

`default_nettype wire
